FILE: sv/glr_pkg.sv
// Package: shared types and constants of the grid linear resampler.
package glr_pkg;

  localparam int unsigned IdxW = 10;
  localparam int unsigned DataW = 32;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic {
    REG_COARSE = 1'b0,
    REG_FINE   = 1'b1
  } reg_e;

  // One query travelling down the pipeline.
  typedef struct packed {
    logic            vld;
    logic            oor;
    logic            interp;
    logic [IdxW-1:0] point;
    logic [IdxW-1:0] mx;
  } qctl_t;

endpackage

FILE: sv/glr_div.sv
// Pipelined restoring divider: one quotient bit per stage, signed numerator.
module glr_div import glr_pkg::*; #(
  parameter int unsigned NumW = 43
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic [IdxW-1:0]        den_i,
  input  qctl_t                  ctl_i,
  output logic                   vld_o,
  output logic signed [NumW-1:0] quo_o,
  output qctl_t                  ctl_o
);

  localparam int unsigned RemW = IdxW + 1;

  logic [NumW:0]     vld_q;
  logic [NumW-1:0]   dvd_q  [NumW+1];
  logic [RemW-1:0]   rem_q  [NumW+1];
  logic [IdxW-1:0]   den_q  [NumW+1];
  logic              neg_q  [NumW+1];
  qctl_t             ctl_q  [NumW+1];

  logic [NumW-1:0] mag;
  assign mag = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NumW-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q[0] <= mag;
    rem_q[0] <= '0;
    den_q[0] <= den_i;
    neg_q[0] <= num_i[NumW-1];
    ctl_q[0] <= ctl_i;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [RemW-1:0] sh;
    logic            ge;
    assign sh = {rem_q[s][IdxW-1:0], dvd_q[s][NumW-1]};
    assign ge = sh >= {1'b0, den_q[s]};
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= ge ? RemW'(sh - {1'b0, den_q[s]}) : sh;
      dvd_q[s+1] <= {dvd_q[s][NumW-2:0], ge};
      den_q[s+1] <= den_q[s];
      neg_q[s+1] <= neg_q[s];
      ctl_q[s+1] <= ctl_q[s];
    end
  end

  // Truncate toward zero: restore the sign on the magnitude quotient.
  assign quo_o = neg_q[NumW] ? -$signed(dvd_q[NumW]) : $signed(dvd_q[NumW]);
  assign vld_o = vld_q[NumW];
  assign ctl_o = ctl_q[NumW];

endmodule

FILE: sv/grid_linear_resampler_unit.sv
// Top level: sample memory, index arithmetic, interpolation and divide pipeline.
//
// Usage:
//   Configuration: write register 0 (coarse_intervals) or 1 (fine_intervals)
//   through cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; write only
//   while no command is in flight. cfg_ready_o is always high.
//   Commands: a transfer happens at a clock edge with start high and busy low.
//   busy is always low, so a command can enter every cycle.
//   op_i = load stores sample_value_i at sample_index_i; no result.
//   op_i = query asks for fine point point_index_i; exactly one result follows
//   on temperature_o/echo_point_o/out_of_range_o, marked by done_o for one cycle.
//   From the accepting edge to done_o a query passes the product, the index
//   divider, memory read, blend products, value divider and output register.
//   Throughput is one command per cycle, set by the dual-read sample memory and
//   the fully pipelined dividers.
//   Loads reach the memory through a delay line, at the edge where a query
//   taken in the same cycle would read it, so each query sees exactly the
//   loads taken before it. Reset sets both registers to 1 and empties the
//   pipeline; sample memory contents are undefined until loaded. The receiver
//   cannot stall: each result is shown once and must be taken.
module grid_linear_resampler_unit import glr_pkg::*; #(
  parameter int unsigned SAMPLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [IdxW-1:0]        cfg_data_i,
  input  logic                   start,
  output logic                   busy,
  input  logic                   op_i,
  input  logic [IdxW-1:0]        sample_index_i,
  input  logic signed [DataW-1:0] sample_value_i,
  input  logic [IdxW-1:0]        point_index_i,
  output logic                   done_o,
  output logic signed [DataW-1:0] temperature_o,
  output logic [IdxW-1:0]        echo_point_o,
  output logic                   out_of_range_o
);

  localparam int unsigned AW   = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int unsigned SW   = (VALUE_WIDTH < DataW) ? VALUE_WIDTH : DataW;
  localparam int unsigned NumW = SW + IdxW + 1;

  logic [IdxW-1:0] m_q, mx_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q  <= IdxW'(1);
      mx_q <= IdxW'(1);
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_COARSE: m_q  <= cfg_data_i;
        REG_FINE:   mx_q <= cfg_data_i;
        default:    m_q  <= m_q;
      endcase
    end
  end

  logic acc;
  assign acc = start && !busy;

  // Stage 1: product point*M and control classification.
  qctl_t             c1_q;
  logic [2*IdxW-1:0] p1_q;
  logic [IdxW-1:0]   m1_q;

  logic [AW-1:0]     widx;
  logic              wen;
  logic signed [SW-1:0] wdat;
  assign wen  = acc && (op_e'(op_i) == OP_LOAD);
  assign widx = AW'(sample_index_i);
  assign wdat = SW'(sample_value_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      p1_q <= '0;
      m1_q <= '0;
    end else begin
      c1_q.vld    <= acc && (op_e'(op_i) == OP_QUERY);
      c1_q.oor    <= point_index_i > mx_q;
      c1_q.interp <= (point_index_i != '0) && (point_index_i < mx_q);
      c1_q.point  <= point_index_i;
      c1_q.mx     <= mx_q;
      p1_q        <= point_index_i * m_q;
      m1_q        <= (point_index_i == '0) ? '0 : m_q;
    end
  end

  // Stage 2: k = p / mx and r = p mod mx by a pipelined restoring divider,
  // one quotient bit per stage over the 2*IdxW-bit product.
  localparam int unsigned KS = 2 * IdxW;
  qctl_t             ck_q [KS+1];
  logic [2*IdxW-1:0] kd_q [KS+1];
  logic [IdxW:0]     kr_q [KS+1];
  logic [IdxW-1:0]   km_q [KS+1];
  logic [KS:0]       kv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kv_q <= '0;
    end else begin
      kv_q <= {kv_q[KS-1:0], c1_q.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    ck_q[0] <= c1_q;
    kd_q[0] <= p1_q;
    kr_q[0] <= '0;
    km_q[0] <= m1_q;
  end

  for (genvar s = 0; s < KS; s++) begin : g_kdiv
    logic [IdxW+1:0] sh;
    logic            ge;
    assign sh = {kr_q[s], kd_q[s][2*IdxW-1]};
    assign ge = sh >= {2'b00, ck_q[s].mx};
    always_ff @(posedge clk_i) begin
      kr_q[s+1] <= ge ? (IdxW+1)'(sh - {2'b00, ck_q[s].mx}) : (IdxW+1)'(sh);
      kd_q[s+1] <= {kd_q[s][2*IdxW-2:0], ge};
      ck_q[s+1] <= ck_q[s];
      km_q[s+1] <= km_q[s];
    end
  end

  qctl_t           ck;
  logic [IdxW-1:0] kq, kr, km;
  logic            kv;
  assign ck = ck_q[KS];
  assign kv = kv_q[KS];
  assign kq = kd_q[KS][IdxW-1:0];
  assign kr = kr_q[KS][IdxW-1:0];
  assign km = km_q[KS];

  // Memory read addresses: interpolation reads k and k+1; end points read
  // sample 0 or sample M.
  logic [IdxW:0] ra0, ra1;
  always_comb begin
    if (ck.interp) begin
      ra0 = {1'b0, kq};
      ra1 = (IdxW+1)'(kq) + 1'b1;
    end else begin
      ra0 = {1'b0, km};
      ra1 = {1'b0, km};
    end
  end

  // Delay each load to the query read stage so writes and reads keep
  // command order and never meet at one edge.
  localparam int unsigned WD = KS + 2;
  logic [WD-1:0]        wv_q;
  logic [AW-1:0]        wa_q [WD];
  logic signed [SW-1:0] wd_q [WD];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q <= '0;
    end else begin
      wv_q <= {wv_q[WD-2:0], wen};
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q[0] <= widx;
    wd_q[0] <= wdat;
    for (int i = 1; i < WD; i++) begin
      wa_q[i] <= wa_q[i-1];
      wd_q[i] <= wd_q[i-1];
    end
  end

  logic signed [SW-1:0] mem [SAMPLE_DEPTH];
  logic signed [SW-1:0] rd0_q, rd1_q;

  always_ff @(posedge clk_i) begin
    if (wv_q[WD-1]) begin
      mem[wa_q[WD-1]] <= wd_q[WD-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rd0_q <= mem[AW'(ra0)];
    rd1_q <= mem[AW'(ra1)];
  end

  qctl_t           c3_q;
  logic [IdxW-1:0] r3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c3_q <= '0;
      r3_q <= '0;
    end else begin
      c3_q.vld    <= kv;
      c3_q.oor    <= ck.oor;
      c3_q.interp <= ck.interp;
      c3_q.point  <= ck.point;
      c3_q.mx     <= ck.mx;
      r3_q        <= kr;
    end
  end

  // Stage 4: two products, registered.
  qctl_t                     c4_q;
  logic signed [NumW-1:0]    pa_q, pb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c4_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
    end else begin
      c4_q.vld    <= c3_q.vld;
      c4_q.oor    <= c3_q.oor;
      c4_q.interp <= c3_q.interp;
      c4_q.point  <= c3_q.point;
      c4_q.mx     <= c3_q.mx;
      if (c3_q.interp) begin
        pa_q <= NumW'(rd0_q) * NumW'($signed({1'b0, IdxW'(c3_q.mx - r3_q)}));
        pb_q <= NumW'(rd1_q) * NumW'($signed({1'b0, r3_q}));
      end else begin
        // End point: numerator S*1, divided by 1.
        pa_q <= NumW'(rd0_q);
        pb_q <= '0;
      end
    end
  end

  // Stage 5: sum, then divide.
  qctl_t                  c5;
  logic signed [NumW-1:0] num5;
  logic [IdxW-1:0]        den5;
  always_comb begin
    c5   = c4_q;
    num5 = NumW'(pa_q + pb_q);
    den5 = c4_q.interp ? c4_q.mx : IdxW'(1);
  end

  logic                   dv;
  logic signed [NumW-1:0] dq;
  qctl_t                  dc;

  glr_div #(.NumW(NumW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (c4_q.vld),
    .num_i  (num5),
    .den_i  (den5),
    .ctl_i  (c5),
    .vld_o  (dv),
    .quo_o  (dq),
    .ctl_o  (dc)
  );

  // Output register: hold each result for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= dv;
    end
  end
  always_ff @(posedge clk_i) begin
    temperature_o  <= dc.oor ? '0 : DataW'(dq);
    echo_point_o   <= dc.point;
    out_of_range_o <= dc.oor;
  end

endmodule
